>>> src/otsu_pkg.sv
// ----------------------------------------------------------------------------
// otsu_pkg
// shared command codes and the control/status bundles of the binarizer
// ----------------------------------------------------------------------------
package otsu_pkg;

  localparam int OP_W = 4;

  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_CLR      = 4'd1;
  localparam logic [OP_W-1:0] OP_SINIT    = 4'd2;
  localparam logic [OP_W-1:0] OP_RD       = 4'd3;
  localparam logic [OP_W-1:0] OP_ACC      = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL_SA   = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL_NB   = 4'd6;
  localparam logic [OP_W-1:0] OP_DIFF     = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL_DEN  = 4'd8;
  localparam logic [OP_W-1:0] OP_SET_DEN  = 4'd9;
  localparam logic [OP_W-1:0] OP_TAKE     = 4'd10;
  localparam logic [OP_W-1:0] OP_MUL_DD   = 4'd11;
  localparam logic [OP_W-1:0] OP_MUL_XB   = 4'd12;
  localparam logic [OP_W-1:0] OP_MUL_EE   = 4'd13;
  localparam logic [OP_W-1:0] OP_MUL_YD   = 4'd14;
  localparam logic [OP_W-1:0] OP_FINISH   = 4'd15;

  typedef struct packed {
    logic            accept;
    logic            inc_t;
    logic [OP_W-1:0] op;
  } otsu_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic skip;
    logic d_zero;
    logic found;
    logic lhs_gt;
    logic t_last;
    logic range_empty;
    logic clr_last;
  } otsu_status_t;

endpackage

>>> src/otsu_threshold_binarizer_unit.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_unit
// two-pass otsu thresholding of 8-bit gray pixels
// ----------------------------------------------------------------------------
// a transfer happens on a clock edge with start high and busy low. command 0
// adds the pixel to the frame histogram, one per cycle while idle; no result.
// with last set the block goes busy, scans thresholds from the frame minimum
// to maximum and emits one threshold result (kind 0, uniform when no
// threshold separates the frame), then clears the frame and drops busy.
// the scan is set by one shared shift-add multiplier, which handles up to seven
// products per threshold, one multiplier bit per cycle.
// command 1 binarizes the pixel against the stored threshold; its result
// is registered at the transfer, one pixel per cycle while idle.
// results show on out_* for one cycle under out_valid; the receiver cannot
// stall. after reset the histogram is cleared level by level with busy high.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer_unit import otsu_pkg::*; #(
  parameter int MAX_PIXELS  = 65536,
  parameter int GRAY_LEVELS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_command,
  input  logic [7:0] in_pixel,
  input  logic       in_last,
  output logic       out_valid,
  output logic       out_kind,
  output logic [7:0] out_threshold,
  output logic [7:0] out_binary_pixel,
  output logic       out_uniform
);

  otsu_cmd_t    cmd;
  otsu_status_t st;

  otsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .in_last    (in_last),
    .st         (st),
    .cmd        (cmd),
    .busy       (busy)
  );

  otsu_dp #(.MAX_PIXELS(MAX_PIXELS), .GRAY_LEVELS(GRAY_LEVELS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_command       (in_command),
    .in_pixel         (in_pixel),
    .st               (st),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_threshold    (out_threshold),
    .out_binary_pixel (out_binary_pixel),
    .out_uniform      (out_uniform)
  );

endmodule

>>> src/otsu_mul.sv
// ----------------------------------------------------------------------------
// otsu_mul
// shift-add multiplier, one multiplier bit per cycle, ends when bits run out
// ----------------------------------------------------------------------------
module otsu_mul #(
  parameter int PW = 118,
  parameter int BW = 42
) (
  input  logic          clk,
  input  logic          ld,
  input  logic [PW-1:0] a_in,
  input  logic [BW-1:0] b_in,
  output logic [PW-1:0] prod,
  output logic          done
);

  logic [PW-1:0] a_r;
  logic [BW-1:0] b_r;
  logic [PW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (ld) begin
      a_r <= a_in;
      b_r <= b_in;
      p_r <= '0;
    end else if (b_r != '0) begin
      if (b_r[0]) p_r <= p_r + a_r;
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign prod = p_r;
  assign done = (b_r == '0);

endmodule

>>> src/otsu_ctrl.sv
// ----------------------------------------------------------------------------
// otsu_ctrl
// sequencer for clearing, threshold search and result issue
// ----------------------------------------------------------------------------
module otsu_ctrl import otsu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         in_command,
  input  logic         in_last,
  input  otsu_status_t st,
  output otsu_cmd_t    cmd,
  output logic         busy
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_DRAIN = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_ACC   = 5'd4;
  localparam logic [4:0] S_CHK   = 5'd5;
  localparam logic [4:0] S_WA    = 5'd6;
  localparam logic [4:0] S_WB    = 5'd7;
  localparam logic [4:0] S_DZ    = 5'd8;
  localparam logic [4:0] S_WDEN  = 5'd9;
  localparam logic [4:0] S_FND   = 5'd10;
  localparam logic [4:0] S_W1    = 5'd11;
  localparam logic [4:0] S_W2    = 5'd12;
  localparam logic [4:0] S_W3    = 5'd13;
  localparam logic [4:0] S_W4    = 5'd14;
  localparam logic [4:0] S_NXT   = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = accept;
    cmd.inc_t  = 1'b0;
    cmd.op     = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (accept && !in_command && in_last) state_nxt = S_DRAIN;
      end
      S_CLR: begin
        cmd.op = OP_CLR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_DRAIN: begin
        cmd.op    = OP_SINIT;
        state_nxt = st.range_empty ? S_FIN : S_RD;
      end
      S_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (st.skip) begin
          state_nxt = S_NXT;
        end else begin
          cmd.op    = OP_MUL_SA;
          state_nxt = S_WA;
        end
      end
      S_WA: begin
        if (st.mul_done) begin
          cmd.op    = OP_MUL_NB;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (st.mul_done) begin
          cmd.op    = OP_DIFF;
          state_nxt = S_DZ;
        end
      end
      S_DZ: begin
        if (st.d_zero) begin
          state_nxt = S_NXT;
        end else begin
          cmd.op    = OP_MUL_DEN;
          state_nxt = S_WDEN;
        end
      end
      S_WDEN: begin
        if (st.mul_done) begin
          cmd.op    = OP_SET_DEN;
          state_nxt = S_FND;
        end
      end
      S_FND: begin
        if (!st.found) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_NXT;
        end else begin
          cmd.op    = OP_MUL_DD;
          state_nxt = S_W1;
        end
      end
      S_W1: begin
        if (st.mul_done) begin
          cmd.op    = OP_MUL_XB;
          state_nxt = S_W2;
        end
      end
      S_W2: begin
        if (st.mul_done) begin
          cmd.op    = OP_MUL_EE;
          state_nxt = S_W3;
        end
      end
      S_W3: begin
        if (st.mul_done) begin
          cmd.op    = OP_MUL_YD;
          state_nxt = S_W4;
        end
      end
      S_W4: begin
        if (st.mul_done) begin
          if (st.lhs_gt) cmd.op = OP_TAKE;
          state_nxt = S_NXT;
        end
      end
      S_NXT: begin
        if (st.t_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.inc_t = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        cmd.op    = OP_FINISH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/otsu_dp.sv
// ----------------------------------------------------------------------------
// otsu_dp
// histogram memory, frame accumulators, search registers and result register
// ----------------------------------------------------------------------------
module otsu_dp import otsu_pkg::*; #(
  parameter int MAX_PIXELS  = 65536,
  parameter int GRAY_LEVELS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  otsu_cmd_t    cmd,
  input  logic         in_command,
  input  logic [7:0]   in_pixel,
  output otsu_status_t st,
  output logic         out_valid,
  output logic         out_kind,
  output logic [7:0]   out_threshold,
  output logic [7:0]   out_binary_pixel,
  output logic         out_uniform
);

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int SW = CW + 8;
  localparam int AW = SW + CW;
  localparam int DW = 2 * CW;
  localparam int PW = 2 * AW + 2 * CW;
  localparam int LW = (GRAY_LEVELS > 1) ? $clog2(GRAY_LEVELS) : 1;
  localparam logic [8:0] GL9 = 9'(GRAY_LEVELS);
  localparam logic [7:0] TOP_LEVEL = 8'(GRAY_LEVELS - 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_PIXELS);

  logic [CW-1:0] mem [GRAY_LEVELS];

  logic [CW-1:0] count_r;
  logic [SW-1:0] sum_r;
  logic [7:0]    min_r, max_r;
  logic [7:0]    stored_r;

  logic          wr_pend_r;
  logic [LW-1:0] wr_addr_r;
  logic [CW-1:0] rd_data_r;
  logic          last_v_r;
  logic [LW-1:0] last_addr_r;
  logic [CW-1:0] last_val_r;

  logic [7:0]    t_r;
  logic [CW-1:0] cl_r;
  logic [SW-1:0] sl_r;
  logic [AW-1:0] a_r, d_r, best_d_r;
  logic [DW-1:0] den_r, best_den_r;
  logic [PW-1:0] lhs_r;
  logic [7:0]    thr_r;
  logic          found_r;

  logic [7:0]    pix_c;
  logic          acc_go;
  logic [CW-1:0] hist_inc;
  logic [CW-1:0] ch;
  logic [PW-1:0] prod;
  logic          mul_done;
  logic          mul_ld;
  logic [PW-1:0] mul_a;
  logic [AW-1:0] mul_b;
  logic [AW-1:0] prod_lo;
  logic [7:0]    fin_thr;

  assign pix_c    = ({1'b0, in_pixel} >= GL9) ? TOP_LEVEL : in_pixel;
  assign acc_go   = cmd.accept && !in_command && (count_r < CAP);
  assign hist_inc = ((last_v_r && last_addr_r == wr_addr_r) ? last_val_r : rd_data_r) + 1'b1;
  assign ch       = count_r - cl_r;
  assign prod_lo  = prod[AW-1:0];
  assign fin_thr  = found_r ? thr_r : 8'd0;

  always_comb begin
    mul_ld = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_MUL_SA: begin
        mul_a = PW'(sum_r);
        mul_b = AW'(cl_r);
      end
      OP_MUL_NB: begin
        mul_a = PW'(sl_r);
        mul_b = AW'(count_r);
      end
      OP_MUL_DEN: begin
        mul_a = PW'(cl_r);
        mul_b = AW'(ch);
      end
      OP_MUL_DD: begin
        mul_a = PW'(d_r);
        mul_b = d_r;
      end
      OP_MUL_XB: begin
        mul_a = prod;
        mul_b = AW'(best_den_r);
      end
      OP_MUL_EE: begin
        mul_a = PW'(best_d_r);
        mul_b = best_d_r;
      end
      OP_MUL_YD: begin
        mul_a = prod;
        mul_b = AW'(den_r);
      end
      default: mul_ld = 1'b0;
    endcase
  end

  otsu_mul #(.PW(PW), .BW(AW)) u_mul (
    .clk  (clk),
    .ld   (mul_ld),
    .a_in (mul_a),
    .b_in (mul_b),
    .prod (prod),
    .done (mul_done)
  );

  always_comb begin
    st.mul_done    = mul_done;
    st.skip        = (cl_r == '0) || (ch == '0);
    st.d_zero      = (d_r == '0);
    st.found       = found_r;
    st.lhs_gt      = lhs_r > prod;
    st.t_last      = (t_r == max_r);
    st.range_empty = (count_r == '0);
    st.clr_last    = (t_r == TOP_LEVEL);
  end

  // histogram port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLR) begin
      mem[t_r[LW-1:0]] <= '0;
    end else if (cmd.op == OP_RD) begin
      rd_data_r        <= mem[t_r[LW-1:0]];
      mem[t_r[LW-1:0]] <= '0;
    end else begin
      if (acc_go) rd_data_r <= mem[pix_c[LW-1:0]];
      if (wr_pend_r) mem[wr_addr_r] <= hist_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
      last_v_r  <= 1'b0;
      count_r   <= '0;
      sum_r     <= '0;
      min_r     <= 8'd255;
      max_r     <= 8'd0;
      stored_r  <= 8'd0;
      t_r       <= 8'd0;
      found_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wr_pend_r <= acc_go;
      wr_addr_r <= pix_c[LW-1:0];
      last_v_r  <= wr_pend_r;
      if (wr_pend_r) begin
        last_addr_r <= wr_addr_r;
        last_val_r  <= hist_inc;
      end
      if (acc_go) begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SW'(pix_c);
        if (pix_c < min_r) min_r <= pix_c;
        if (pix_c > max_r) max_r <= pix_c;
      end
      out_valid <= 1'b0;
      if (cmd.accept && in_command) begin
        out_valid        <= 1'b1;
        out_kind         <= 1'b1;
        out_threshold    <= stored_r;
        out_binary_pixel <= (in_pixel > stored_r) ? 8'd255 : 8'd0;
        out_uniform      <= 1'b0;
      end
      if (cmd.inc_t) t_r <= t_r + 1'b1;
      case (cmd.op)
        OP_CLR: t_r <= t_r + 1'b1;
        OP_SINIT: begin
          cl_r    <= '0;
          sl_r    <= '0;
          found_r <= 1'b0;
          t_r     <= min_r;
        end
        OP_ACC: begin
          cl_r <= cl_r + rd_data_r;
          sl_r <= sl_r + SW'(t_r * rd_data_r);
        end
        OP_MUL_NB: a_r <= prod_lo;
        OP_DIFF:   d_r <= (a_r > prod_lo) ? a_r - prod_lo : prod_lo - a_r;
        OP_SET_DEN: den_r <= prod[DW-1:0];
        OP_MUL_EE: lhs_r <= prod;
        OP_TAKE: begin
          best_d_r   <= d_r;
          best_den_r <= den_r;
          thr_r      <= t_r;
          found_r    <= 1'b1;
        end
        OP_FINISH: begin
          out_valid        <= 1'b1;
          out_kind         <= 1'b0;
          out_threshold    <= fin_thr;
          out_binary_pixel <= 8'd0;
          out_uniform      <= !found_r;
          stored_r         <= fin_thr;
          count_r          <= '0;
          sum_r            <= '0;
          min_r            <= 8'd255;
          max_r            <= 8'd0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> dv/otsu_threshold_binarizer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_unit_test
// self-checking bench for the two-pass otsu binarizer: frames of gray pixels
// are accumulated and searched by a local threshold predictor, binarize
// commands are checked against the stored threshold, with bursty input
// ----------------------------------------------------------------------------
class otsu_scoreboard;
  typedef struct {
    bit       kind;
    bit [7:0] thr;
    bit [7:0] bin;
    bit       uni;
  } otsu_result_t;

  int unsigned      hist [256];
  bit [16:0]        npix;
  bit [23:0]        lsum;
  bit [7:0]         lo_lvl;
  bit [7:0]         hi_lvl;
  bit [7:0]         thr_q;
  otsu_result_t     pending [$];
  int               errors;
  int unsigned      max_pix;

  function new(int unsigned mp);
    max_pix = mp;
    errors  = 0;
    thr_q   = 8'd0;
    clear_frame();
  endfunction

  function void clear_frame();
    foreach (hist[i]) hist[i] = 0;
    npix   = '0;
    lsum   = '0;
    lo_lvl = 8'd255;
    hi_lvl = 8'd0;
  endfunction

  // exact search: returns 1 when some threshold has positive variance
  function bit find_threshold(output bit [7:0] thr);
    bit [63:0]  n, s, cl, sl, ch, a, b, d, den, best_d, best_den;
    bit [191:0] lhs, rhs;
    bit         found;
    found = 0;
    thr   = 8'd0;
    n = npix;
    s = lsum;
    cl = 0;
    sl = 0;
    best_d = 0;
    best_den = 0;
    if (n == 0) return 0;
    for (int t = lo_lvl; t <= hi_lvl; t++) begin
      cl += hist[t];
      sl += t * hist[t];
      ch = n - cl;
      if (cl == 0 || ch == 0) continue;
      a = s * cl;
      b = n * sl;
      d = (a > b) ? a - b : b - a;
      if (d == 0) continue;
      den = cl * ch;
      if (found) begin
        lhs = d;
        lhs = lhs * d;
        lhs = lhs * best_den;
        rhs = best_d;
        rhs = rhs * best_d;
        rhs = rhs * den;
        if (lhs <= rhs) continue;
      end
      found    = 1;
      best_d   = d;
      best_den = den;
      thr      = t[7:0];
    end
    return found;
  endfunction

  function void note_transfer(bit cmd, bit [7:0] pix, bit lst);
    otsu_result_t r;
    bit [7:0]     t;
    bit           ok;
    if (cmd) begin
      r.kind = 1;
      r.thr  = thr_q;
      r.bin  = (pix > thr_q) ? 8'd255 : 8'd0;
      r.uni  = 0;
      pending.push_back(r);
      return;
    end
    if (npix < max_pix) begin
      hist[pix]++;
      npix++;
      lsum += pix;
      if (pix < lo_lvl) lo_lvl = pix;
      if (pix > hi_lvl) hi_lvl = pix;
    end
    if (lst) begin
      ok    = find_threshold(t);
      thr_q = ok ? t : 8'd0;
      clear_frame();
      r.kind = 0;
      r.thr  = thr_q;
      r.bin  = 8'd0;
      r.uni  = !ok;
      pending.push_back(r);
    end
  endfunction

  function void check_result(bit kind, bit [7:0] thr, bit [7:0] bin, bit uni);
    otsu_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result kind=%0d thr=%0d bin=%0d uniform=%0d",
               $time, kind, thr, bin, uni);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.kind !== kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
      errors++;
    end
    if (e.thr !== thr) begin
      $display("%0t: threshold expected %0d actual %0d", $time, e.thr, thr);
      errors++;
    end
    if (e.bin !== bin) begin
      $display("%0t: binary_pixel expected %0d actual %0d", $time, e.bin, bin);
      errors++;
    end
    if (e.uni !== uni) begin
      $display("%0t: uniform expected %0d actual %0d", $time, e.uni, uni);
      errors++;
    end
  endfunction
endclass

module otsu_threshold_binarizer_unit_test;

  localparam int          MAX_PIX     = 64;
  localparam int          LVLS        = 256;
  localparam int unsigned CYCLE_LIMIT = 50000000;
  localparam bit          CMD_ACC     = 1'b0;
  localparam bit          CMD_BIN     = 1'b1;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_command = 1'b0;
  logic [7:0] in_pixel = 8'd0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_threshold;
  logic [7:0] out_binary_pixel;
  logic       out_uniform;

  otsu_scoreboard sb = new(MAX_PIX);
  int unsigned    cycles = 0;
  int             burst_left = 0;
  int             item_count = 0;

  otsu_threshold_binarizer_unit #(.MAX_PIXELS(MAX_PIX), .GRAY_LEVELS(LVLS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_pixel(in_pixel), .in_last(in_last),
    .out_valid(out_valid), .out_kind(out_kind), .out_threshold(out_threshold),
    .out_binary_pixel(out_binary_pixel), .out_uniform(out_uniform)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // results change only at rising edges, so sample them at the falling edge
  always @(negedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_kind, out_threshold, out_binary_pixel, out_uniform);
  end

  task automatic send_item(bit cmd, bit [7:0] pix, bit lst);
    bit ok;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(40, 120))
                                               : int'($urandom_range(1, 20));
    end
    burst_left--;
    start      <= 1'b1;
    in_command <= cmd;
    in_pixel   <= pix;
    in_last    <= lst;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    sb.note_transfer(cmd, pix, lst);
    item_count++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_frame();
    int base, spread, len;
    spread = ($urandom_range(0, 40) == 0) ? 255 : int'($urandom_range(0, 15));
    base   = int'($urandom_range(0, 255 - spread));
    len    = int'($urandom_range(1, 30));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(CMD_BIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(CMD_ACC, 8'(base + int'($urandom_range(0, spread))), i == len - 1);
    end
    repeat ($urandom_range(0, 25))
      send_item(CMD_BIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // stored threshold zero after reset, last ignored on binarize
    send_item(CMD_BIN, 8'd0, 1'b1);
    send_item(CMD_BIN, 8'd1, 1'b0);
    send_item(CMD_BIN, 8'd255, 1'b1);
    // single pixel frame and single level frame give uniform
    send_item(CMD_ACC, 8'd200, 1'b1);
    send_item(CMD_ACC, 8'd7, 1'b0);
    send_item(CMD_ACC, 8'd7, 1'b0);
    send_item(CMD_ACC, 8'd7, 1'b1);
    // extremes of the gray range
    send_item(CMD_ACC, 8'd0, 1'b0);
    send_item(CMD_ACC, 8'd0, 1'b0);
    send_item(CMD_ACC, 8'd255, 1'b1);
    send_item(CMD_BIN, 8'd0, 1'b0);
    send_item(CMD_BIN, 8'd255, 1'b0);
    send_item(CMD_BIN, 8'd128, 1'b1);
    // ties between thresholds keep the earliest
    send_item(CMD_ACC, 8'd10, 1'b0);
    send_item(CMD_ACC, 8'd20, 1'b0);
    send_item(CMD_ACC, 8'd30, 1'b1);
    send_item(CMD_BIN, 8'd10, 1'b0);
    send_item(CMD_BIN, 8'd11, 1'b0);

    // pause until every result is back, then overfill one frame
    wait_drained();
    for (int i = 0; i < MAX_PIX + 3; i++)
      send_item(CMD_ACC, (i % 3 == 0) ? 8'd200 : 8'd10, 1'b0);
    send_item(CMD_ACC, 8'd255, 1'b1);
    send_item(CMD_BIN, 8'd199, 1'b0);

    while (item_count < 500) random_frame();

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
